@@ rtl/bbl_pkg.sv @@
// ----------------------------------------------------------------------------
// bbl_pkg
// Shared constants and types of the box blur line filter.
// ----------------------------------------------------------------------------
package bbl_pkg;

    // default sizing
    localparam int MAX_RADIUS_DEF  = 15;
    localparam int SAMPLE_BITS_DEF = 16;

    // configuration register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int RADIUS_W   = 4;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd1;

    // register index, taken from paddr[APB_ADDR_W-1]
    localparam logic REG_RADIUS = 1'b0;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } bbl_div_stat_t;

endpackage : bbl_pkg

@@ rtl/bbl_in_if.sv @@
// ----------------------------------------------------------------------------
// bbl_in_if
// Sample stream channel: one sample of a line per transfer.
// ----------------------------------------------------------------------------
interface bbl_in_if #(
    parameter int SAMPLE_BITS = bbl_pkg::SAMPLE_BITS_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          line_end;

    modport source (output valid, output sample, output line_end, input ready);
    modport sink   (input valid, input sample, input line_end, output ready);

endinterface : bbl_in_if

@@ rtl/bbl_out_if.sv @@
// ----------------------------------------------------------------------------
// bbl_out_if
// Result stream channel: one window average per transfer.
// ----------------------------------------------------------------------------
interface bbl_out_if #(
    parameter int SAMPLE_BITS = bbl_pkg::SAMPLE_BITS_DEF
) ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          last_of_line;

    modport source (output valid, output average, output last_of_line, input ready);
    modport sink   (input valid, input average, input last_of_line, output ready);

endinterface : bbl_out_if

@@ rtl/box_blur_line_filter.sv @@
// ----------------------------------------------------------------------------
// box_blur_line_filter
// Streaming 1-D box filter over one line with edge-aware divisor.
// ----------------------------------------------------------------------------
// Each output is the mean of the samples within radius positions that lie
// inside the line, truncated toward zero; outputs lag the input by radius
// samples and the line_end sample flushes the rest, the final one flagged
// last_of_line. Recent samples sit in a ring memory of 2*MAX_RADIUS+2 entries
// with a registered read port. The block works on one sample at a time; a
// sample that yields an output waits for the bit-serial divider, which
// makes one quotient bit per cycle, and for a free output register, and each
// further output of a flush fetches one sample from the ring and divides
// again. A new sample is taken while the previous result still waits in the
// output register. Writing radius drops the line in progress.
// ----------------------------------------------------------------------------
module box_blur_line_filter #(
    parameter int MAX_RADIUS  = bbl_pkg::MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = bbl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bbl_in_if.sink                           line_in,
    bbl_out_if.source                        avg_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bbl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bbl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bbl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import bbl_pkg::*;

    localparam int DEPTH    = 2 * MAX_RADIUS + 2;
    localparam int FILL_MAX = 2 * MAX_RADIUS + 1;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(FILL_MAX + 1);
    localparam int RAD_W    = $clog2(MAX_RADIUS + 1);
    localparam int SUM_W    = SAMPLE_BITS + CNT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ADD   = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_FREAD = 2'd3;

    function automatic logic [CNT_W-1:0] cnt_min(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        cnt_min = (a < b) ? a : b;
    endfunction

    // slot of the sample k positions behind the one just before wp
    function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] wp,
                                                    input logic [CNT_W-1:0]  k);
        logic [ADDR_W:0] t;
        t = (ADDR_W+1)'(wp) + (ADDR_W+1)'(DEPTH - 1) - (ADDR_W+1)'(k);
        if (t >= (ADDR_W+1)'(DEPTH))
            t = t - (ADDR_W+1)'(DEPTH);
        ring_addr = t[ADDR_W-1:0];
    endfunction

    // ring memory
    logic signed [SAMPLE_BITS-1:0] ring_mem [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_raddr;

    // control state
    logic [1:0]              state_reg, state_next;
    logic [RADIUS_W-1:0]     radius_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [ADDR_W-1:0]       wp_reg, wp_next;
    logic                    out_valid_reg, out_valid_next;

    // per-item working registers
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic                          end_reg;
    logic [CNT_W-1:0]              d_reg, d_next;
    logic [CNT_W-1:0]              back_reg, back_next;
    logic                          flush_reg, flush_next;
    logic                          last_reg, last_next;
    logic                          sub_reg, sub_next;
    logic signed [SAMPLE_BITS-1:0] out_avg_reg;
    logic                          out_last_reg;

    logic [RAD_W-1:0]        r_eff;
    logic [CNT_W-1:0]        r_c;
    logic [CNT_W-1:0]        two_r;
    logic                    in_xfer;
    logic                    cfg_wr;
    logic                    out_load;
    logic signed [SUM_W-1:0] rd_ext;
    logic signed [SUM_W-1:0] smp_ext;
    logic [CNT_W-1:0]        fill_inc;
    logic [CNT_W-1:0]        back_new;
    logic [CNT_W-1:0]        d_first;
    logic [CNT_W-1:0]        d_dec;
    logic [CNT_W-1:0]        k_back;

    logic                          div_start;
    logic signed [SUM_W-1:0]       div_dividend;
    logic [CNT_W-1:0]              div_divisor;
    logic signed [SAMPLE_BITS-1:0] div_quot;
    bbl_div_stat_t                 div_stat;

    assign r_eff = (32'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                   : RAD_W'(radius_reg);
    assign r_c   = CNT_W'(r_eff);
    assign two_r = CNT_W'({r_eff, 1'b0});

    assign in_xfer       = line_in.valid && line_in.ready;
    assign line_in.ready = (state_reg == S_IDLE);

    assign avg_out.valid        = out_valid_reg;
    assign avg_out.average      = out_avg_reg;
    assign avg_out.last_of_line = out_last_reg;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_RADIUS);
    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_RADIUS) ? APB_DATA_W'(radius_reg) : '0;

    assign rd_ext  = {{(SUM_W-SAMPLE_BITS){rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};
    assign smp_ext = {{(SUM_W-SAMPLE_BITS){smp_reg[SAMPLE_BITS-1]}}, smp_reg};

    assign fill_inc = (fill_reg < CNT_W'(FILL_MAX)) ? fill_reg + CNT_W'(1) : fill_reg;
    assign back_new = fill_inc - CNT_W'(1);
    assign d_first  = cnt_min(r_c, back_new);
    assign d_dec    = d_reg - CNT_W'(1);
    assign k_back   = d_reg + r_c;

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;
        wp_next        = wp_reg;
        d_next         = d_reg;
        back_next      = back_reg;
        flush_next     = flush_reg;
        last_next      = last_reg;
        sub_next       = sub_reg;
        mem_we         = 1'b0;
        mem_raddr      = ring_addr(wp_reg, two_r);
        div_start      = 1'b0;
        div_dividend   = sum_reg;
        div_divisor    = CNT_W'(1);
        out_load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    // store the sample; fetch the one leaving the window
                    mem_we     = 1'b1;
                    mem_raddr  = ring_addr(wp_reg, two_r);
                    wp_next    = (wp_reg == ADDR_W'(DEPTH - 1)) ? '0
                                                                : wp_reg + ADDR_W'(1);
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                sum_next  = sum_reg + smp_ext - ((fill_reg > two_r) ? rd_ext : '0);
                fill_next = fill_inc;
                back_next = back_new;
                div_dividend = sum_next;
                if (!end_reg)
                begin
                    flush_next  = 1'b0;
                    last_next   = 1'b0;
                    div_divisor = cnt_min(two_r, back_new) + CNT_W'(1);
                    if (back_new >= r_c)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    flush_next  = 1'b1;
                    d_next      = d_first;
                    last_next   = (d_first == '0);
                    div_divisor = cnt_min(d_first + r_c, back_new) + CNT_W'(1);
                    div_start   = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done && (!out_valid_reg || avg_out.ready))
                begin
                    out_load = 1'b1;
                    if (!flush_reg || last_reg)
                    begin
                        if (flush_reg)
                        begin
                            sum_next  = '0;
                            fill_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // no writes during a flush, so this read cannot collide
                        sub_next   = (k_back <= back_reg);
                        mem_raddr  = ring_addr(wp_reg, k_back);
                        state_next = S_FREAD;
                    end
                end
            end
            S_FREAD:
            begin
                sum_next     = sum_reg - (sub_reg ? rd_ext : '0);
                d_next       = d_dec;
                last_next    = (d_dec == '0);
                div_dividend = sum_next;
                div_divisor  = cnt_min(d_dec + r_c, back_reg) + CNT_W'(1);
                div_start    = 1'b1;
                state_next   = S_DIV;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a radius write drops the line in progress
        if (cfg_wr)
        begin
            sum_next  = '0;
            fill_next = '0;
        end

        out_valid_next = out_load ? 1'b1 : (avg_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[wp_reg] <= line_in.sample;
        rd_data_reg <= ring_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= RADIUS_RESET;
            sum_reg       <= '0;
            fill_reg      <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
                radius_reg <= pwdata[RADIUS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            smp_reg <= line_in.sample;
            end_reg <= line_in.line_end;
        end
        d_reg     <= d_next;
        back_reg  <= back_next;
        flush_reg <= flush_next;
        last_reg  <= last_next;
        sub_reg   <= sub_next;
        if (out_load)
        begin
            out_avg_reg  <= div_quot;
            out_last_reg <= last_reg;
        end
    end

    bbl_div #(
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(FILL_MAX))
        else $error("fill count above window capacity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !line_in.ready)
        else $error("second sample taken before the first was processed");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_fread_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREAD) |-> (flush_reg && !last_reg && ($past(state_reg) == S_DIV)))
        else $error("ring fetch outside a line flush");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !avg_out.ready) |=> ($stable(out_avg_reg) && out_valid_reg))
        else $error("pending result overwritten");
`endif

endmodule : box_blur_line_filter

@@ rtl/bbl_div.sv @@
// ----------------------------------------------------------------------------
// bbl_div
// Restoring divider: signed window sum by unsigned in-line count, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module bbl_div #(
    parameter int SUM_W       = 21,
    parameter int CNT_W       = 5,
    parameter int SAMPLE_BITS = bbl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SUM_W-1:0]       dividend,
    input  logic        [CNT_W-1:0]       divisor,
    output logic signed [SAMPLE_BITS-1:0] quotient,
    output bbl_pkg::bbl_div_stat_t        stat
);
    import bbl_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              fits;
    logic [SUM_W-1:0]  mag;
    logic [SUM_W-1:0]  q_full;

    assign shifted = {rem_reg, acc_reg[SUM_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    assign q_full  = neg_reg ? SUM_W'(~acc_reg + SUM_W'(1)) : acc_reg;

    // the mean of in-range samples always fits the sample width
    assign quotient  = signed'(q_full[SAMPLE_BITS-1:0]);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(SUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (divisor != '0))
        else $error("divider started with a zero count");

    a_div_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !stat.busy)
        else $error("divider done while still busy");

    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (step_reg != STEP_W'(1)) |=> busy_reg)
        else $error("divider stopped early");
`endif

endmodule : bbl_div
